### rtl/hmd_pkg.sv
package hmd_pkg;

  localparam int CODE_BITS = 15;
  localparam int DATA_BITS = 11;
  localparam int BYTE_BITS = 8;
  localparam int SYN_BITS  = 4;
  localparam int PEND_BITS = 7;
  localparam int CNT_BITS  = 3;
  localparam int N_BITS    = 5;
  localparam int ACC_BITS  = PEND_BITS + DATA_BITS;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [SYN_BITS-1:0]  syn_t;
  typedef logic [BYTE_BITS-1:0] byte_t;
  typedef logic [PEND_BITS-1:0] pend_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [N_BITS-1:0]    nbits_t;
  typedef logic [ACC_BITS-1:0]  acc_t;

  // Hamming positions of the data bits, oldest first
  localparam syn_t DATA_POS [DATA_BITS] = '{
    4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  // Decoded codeword handed to the packer
  typedef struct packed {
    data_t data;
    syn_t  syn;
    logic  eom;
  } dec_t;

  // XOR of the positions of all set bits
  function automatic syn_t syndrome_of(code_t word);
    syn_t s;
    s = '0;
    for (int k = 0; k < CODE_BITS; k++) begin
      if (word[k]) begin
        s = s ^ SYN_BITS'(k + 1);
      end
    end
    return s;
  endfunction

endpackage

### rtl/hmd_decode.sv
module hmd_decode
  import hmd_pkg::*;
(
  input  code_t codeword_i,
  input  logic  eom_i,
  output dec_t  dec_o
);

  syn_t  syn;
  code_t fixed;
  code_t flip;

  // Form syndrome and flip the named position
  always_comb begin
    syn  = syndrome_of(codeword_i);
    flip = (syn != '0) ? (code_t'(1) << (syn - syn_t'(1))) : '0;
    fixed = codeword_i ^ flip;
  end

  // Gather data bits, first one at the top
  always_comb begin
    dec_o.syn = syn;
    dec_o.eom = eom_i;
    for (int j = 0; j < DATA_BITS; j++) begin
      dec_o.data[DATA_BITS-1-j] = fixed[DATA_POS[j] - syn_t'(1)];
    end
  end

endmodule

### rtl/hmd_packer.sv
module hmd_packer
  import hmd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  dec_t  dec_i,
  output logic  ready_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output byte_t data_byte_o,
  output syn_t  error_position_o,
  output logic  last_of_run_o
);

  pend_t      pend_q, pend_d;
  cnt_t       cnt_q, cnt_d;
  logic [1:0] rem_q, rem_d;
  byte_t      first_q, first_d;
  byte_t      second_q, second_d;
  syn_t       syn_q, syn_d;

  logic   take;
  acc_t   acc;
  nbits_t n;
  nbits_t n_left;
  pend_t  mask;

  assign take    = out_valid_o && !out_stall_i;
  assign ready_o = (rem_q == 2'd0) || (rem_q == 2'd1 && take);

  // Append new data bits to the pending ones and split into bytes
  always_comb begin
    mask     = pend_t'((8'd1 << cnt_q) - 8'd1);
    acc      = {pend_q & mask, dec_i.data};
    n        = nbits_t'(cnt_q) + nbits_t'(DATA_BITS);
    first_d  = first_q;
    second_d = second_q;
    syn_d    = syn_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    n_left   = n - nbits_t'(BYTE_BITS);
    if (take) begin
      rem_d = rem_q - 2'd1;
    end
    if (load_i) begin
      syn_d = dec_i.syn;
      if (n >= nbits_t'(2 * BYTE_BITS)) begin
        first_d  = byte_t'(acc >> (n - nbits_t'(BYTE_BITS)));
        n_left   = n - nbits_t'(2 * BYTE_BITS);
        second_d = byte_t'(acc >> n_left);
        rem_d    = 2'd2;
      end else begin
        second_d = byte_t'(acc >> n_left);
        rem_d    = 2'd1;
      end
      // Drop leftover bits at end of message
      if (dec_i.eom) begin
        pend_d = '0;
        cnt_d  = '0;
      end else begin
        pend_d = pend_t'(acc) & pend_t'((8'd1 << n_left[CNT_BITS-1:0]) - 8'd1);
        cnt_d  = n_left[CNT_BITS-1:0];
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      rem_q  <= rem_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold result words
  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    syn_q    <= syn_d;
  end

  assign out_valid_o      = (rem_q != 2'd0);
  assign data_byte_o      = (rem_q == 2'd2) ? first_q : second_q;
  assign error_position_o = syn_q;
  assign last_of_run_o    = (rem_q == 2'd1);

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 2'd3)
    else $error("result count out of range");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (rem_q == 2'd0 || (rem_q == 2'd1 && take)))
    else $error("result register overwritten");

  a_second_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && rem_q == 2'd2) |=> (rem_q == 2'd1 && $stable(syn_q)))
    else $error("second word lost");

  a_eom_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && dec_i.eom) |=> (cnt_q == '0))
    else $error("pending bits kept after end of message");

endmodule

### rtl/hamming_15_11_decode_byte_pack_core.sv
// Hamming(15,11) decoder with byte packing.
//
// Input channel: in_valid_i / in_stall_o carry one 15-bit codeword and an
// end_of_message flag per word. Output channel: out_valid_o / out_stall_i
// carry one data byte per transfer, with the syndrome of its codeword and a
// flag on the last byte that codeword produced.
//
// Each codeword is corrected (single error), its 11 data bits are appended
// to up to 7 pending bits, and every full byte leaves MSB first: one or two
// bytes per codeword. Leftover bits are dropped after end_of_message.
//
// The input register holds each codeword while it is decoded; the packer
// registers the bytes it yields. The output port gives one byte per cycle
// while the receiver does not stall, and a new codeword enters the packer
// in the cycle its last pending byte leaves.
//
// Reset clears pending bits and both pipeline stages. When the receiver
// stalls, the result register holds and the input register fills, then
// in_stall_o rises; no word is lost.
module hamming_15_11_decode_byte_pack_core
  import hmd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  code_t codeword_i,
  input  logic  end_of_message_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output byte_t data_byte_o,
  output syn_t  error_position_o,
  output logic  last_of_run_o
);

  logic  s1_valid_q, s1_valid_d;
  code_t s1_code_q;
  logic  s1_eom_q;
  logic  pk_ready;
  logic  pk_load;
  logic  s1_open;
  dec_t  dec;

  assign pk_load    = s1_valid_q && pk_ready;
  assign s1_open    = !s1_valid_q || pk_ready;
  assign in_stall_o = !s1_open;
  assign s1_valid_d = s1_open ? in_valid_i : s1_valid_q;

  // Advance input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_open) begin
      s1_code_q <= codeword_i;
      s1_eom_q  <= end_of_message_i;
    end
  end

  hmd_decode u_decode (
    .codeword_i (s1_code_q),
    .eom_i      (s1_eom_q),
    .dec_o      (dec)
  );

  hmd_packer u_packer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (pk_load),
    .dec_i            (dec),
    .ready_o          (pk_ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .data_byte_o      (data_byte_o),
    .error_position_o (error_position_o),
    .last_of_run_o    (last_of_run_o)
  );

endmodule

### tb/hmd_byte_watch.sv
module hmd_byte_watch
  import hmd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_stall_i,
  input  code_t codeword_i,
  input  logic  end_of_message_i,
  input  logic  out_valid_i,
  input  logic  out_stall_i,
  input  byte_t data_byte_i,
  input  syn_t  error_position_i,
  input  logic  last_of_run_i,
  output int    fail_count_o,
  output int    bytes_owed_o
);

  typedef struct {
    byte_t data;
    syn_t  pos;
    logic  last;
  } due_byte_t;

  // Bytes still owed by the block, oldest first
  due_byte_t bytes_due[$];

  // Data bits not yet packed into a byte
  pend_t carry_bits  = '0;
  cnt_t  carry_count = '0;

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count_o++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
  endtask

  // Correct one word, append its data bits and queue every full byte
  task automatic decode_and_pack(input code_t word, input logic eom);
    syn_t      pos;
    code_t     fixed;
    acc_t      acc;
    int        n;
    due_byte_t b;
    pos = '0;
    for (int k = 0; k < CODE_BITS; k++) begin
      if (word[k]) begin
        pos ^= syn_t'(k + 1);
      end
    end
    fixed = word;
    if (pos != '0) begin
      fixed[pos - 1] = ~fixed[pos - 1];
    end
    // data bits sit at every position that is not a power of two
    acc = acc_t'(carry_bits);
    for (int p = 1; p <= CODE_BITS; p++) begin
      if ((p & (p - 1)) != 0) begin
        acc = {acc[ACC_BITS-2:0], fixed[p-1]};
      end
    end
    n = int'(carry_count) + DATA_BITS;
    b.pos = pos;
    n -= BYTE_BITS;
    b.data = acc[n +: BYTE_BITS];
    b.last = (n < BYTE_BITS);
    bytes_due = {bytes_due, b};
    if (n >= BYTE_BITS) begin
      n -= BYTE_BITS;
      b.data = acc[n +: BYTE_BITS];
      b.last = 1'b1;
      bytes_due = {bytes_due, b};
    end
    // drop leftover bits at the end of a message
    if (eom) begin
      carry_bits  = '0;
      carry_count = '0;
    end else begin
      carry_bits  = pend_t'(acc & ((acc_t'(1) << n) - 1'b1));
      carry_count = cnt_t'(n);
    end
  endtask

  always @(posedge clk_i) begin
    due_byte_t want;
    if (rst_ni) begin
      // retire the byte leaving at this edge before queuing new ones
      if (out_valid_i && !out_stall_i) begin
        if (bytes_due.size() == 0) begin
          report_mismatch("unexpected byte", data_byte_i, 0);
        end else begin
          want = bytes_due.pop_front();
          if (data_byte_i !== want.data) begin
            report_mismatch("data_byte", data_byte_i, want.data);
          end
          if (error_position_i !== want.pos) begin
            report_mismatch("error_position", error_position_i, want.pos);
          end
          if (last_of_run_i !== want.last) begin
            report_mismatch("last_of_run", last_of_run_i, want.last);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_and_pack(codeword_i, end_of_message_i);
      end
      bytes_owed_o = bytes_due.size();
    end
  end

endmodule

### tb/hamming_15_11_decode_byte_pack_core_test.sv
module hamming_15_11_decode_byte_pack_core_test;
  import hmd_pkg::*;

  logic  clk_i          = 1'b0;
  logic  rst_ni         = 1'b0;
  logic  in_valid       = 1'b0;
  logic  in_stall;
  code_t codeword       = '0;
  logic  end_of_message = 1'b0;
  logic  out_valid;
  logic  out_stall      = 1'b0;
  byte_t data_byte;
  syn_t  error_position;
  logic  last_of_run;

  int fail_count;
  int bytes_owed;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  hamming_15_11_decode_byte_pack_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .codeword_i      (codeword),
    .end_of_message_i(end_of_message),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .data_byte_o     (data_byte),
    .error_position_o(error_position),
    .last_of_run_o   (last_of_run)
  );

  hmd_byte_watch u_watch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .codeword_i      (codeword),
    .end_of_message_i(end_of_message),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .data_byte_i     (data_byte),
    .error_position_i(error_position),
    .last_of_run_i   (last_of_run),
    .fail_count_o    (fail_count),
    .bytes_owed_o    (bytes_owed)
  );

  function automatic syn_t position_xor(input code_t w);
    syn_t s;
    s = '0;
    for (int k = 0; k < CODE_BITS; k++) begin
      if (w[k]) begin
        s ^= syn_t'(k + 1);
      end
    end
    return s;
  endfunction

  // Mostly valid codewords with zero, one or two flipped bits; rest is noise
  function automatic code_t random_word();
    code_t w;
    syn_t  s;
    int    kind;
    int    a;
    int    b;
    w    = code_t'($urandom);
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      s = position_xor(w);
      if (s != '0) begin
        w[s - 1] = ~w[s - 1];
      end
    end
    if (kind >= 3 && kind <= 6) begin
      a = $urandom_range(0, CODE_BITS - 1);
      w[a] = ~w[a];
      if (kind == 6) begin
        b = (a + $urandom_range(1, CODE_BITS - 1)) % CODE_BITS;
        w[b] = ~w[b];
      end
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input code_t w, input logic eom);
    int gap;
    if ($urandom_range(0, 59) == 0) begin
      send_burst = ~send_burst;
    end
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    codeword       <= w;
    end_of_message <= eom;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Hold off input until every owed byte has left
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (bytes_owed != 0);
    @(posedge clk_i);
  endtask

  // Receiver: sometimes stall before taking each byte; in bursts, never stall
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 59) == 0) begin
        recv_burst = ~recv_burst;
      end
      hold = recv_burst ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, every single-bit word (each syndrome), a double error,
    // and end of message with bits pending and with none
    send_word(15'h0000, 1'b0);
    send_word(15'h7fff, 1'b0);
    for (int k = 0; k < CODE_BITS; k++) begin
      send_word(code_t'(1) << k, k == 4);
    end
    send_word(15'h0003, 1'b0);
    send_word(15'h7fff, 1'b1);
    send_word(15'h0000, 1'b1);

    for (int i = 0; i < 1530; i++) begin
      if (i == 700) begin
        wait_drained();
      end
      send_word(random_word(), $urandom_range(0, 7) == 0);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("hamming_15_11_decode_byte_pack_core verification clean");
    end else begin
      $display("hamming_15_11_decode_byte_pack_core verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("hamming_15_11_decode_byte_pack_core verification failed");
    $finish;
  end

endmodule
